FILE: hw/rtl/complex_arithmetic_unit_macros.svh
// Assertion macros for the complex arithmetic unit.
`ifndef COMPLEX_ARITHMETIC_UNIT_MACROS_SVH
`define COMPLEX_ARITHMETIC_UNIT_MACROS_SVH
`ifndef SYNTHESIS
`define CAU_ASSERT_IMPL(label, clk, rst, lhs, rhs) \
   label: assert property (@(posedge clk) disable iff (rst) (lhs) |-> (rhs)) \
      else $error("cau assertion failed");
`define CAU_ASSERT_NEXT(label, clk, rst, lhs, rhs) \
   label: assert property (@(posedge clk) disable iff (rst) (lhs) |=> (rhs)) \
      else $error("cau assertion failed");
`else
`define CAU_ASSERT_IMPL(label, clk, rst, lhs, rhs)
`define CAU_ASSERT_NEXT(label, clk, rst, lhs, rhs)
`endif
`endif

FILE: hw/rtl/cau_pkg.sv
// Types and codes shared by the complex arithmetic unit modules.
`default_nettype none
package cau_pkg;
   localparam int DATA_WIDTH = 16;
   localparam int SUM_WIDTH  = 2 * DATA_WIDTH + 2;
   localparam int DEN_WIDTH  = 2 * DATA_WIDTH + 1;

   localparam logic [2:0] CMD_ADD = 3'd0;
   localparam logic [2:0] CMD_SUB = 3'd1;
   localparam logic [2:0] CMD_MUL = 3'd2;
   localparam logic [2:0] CMD_DIV = 3'd3;
   localparam logic [2:0] CMD_MAG = 3'd4;
   localparam logic [2:0] CMD_NEG = 3'd5;

   localparam logic [1:0] ST_OK   = 2'd0;
   localparam logic [1:0] ST_SAT  = 2'd1;
   localparam logic [1:0] ST_DIV0 = 2'd2;

   typedef struct packed {
      logic [2:0]                   cmd;
      logic signed [DATA_WIDTH-1:0] left_real;
      logic signed [DATA_WIDTH-1:0] left_imag;
      logic signed [DATA_WIDTH-1:0] right_real;
      logic signed [DATA_WIDTH-1:0] right_imag;
   } req_type;

   typedef struct packed {
      logic signed [DATA_WIDTH-1:0] res_real;
      logic signed [DATA_WIDTH-1:0] res_imag;
      logic [1:0]                   status;
   } rsp_type;

   // prepared request between front and back
   typedef struct packed {
      logic [2:0]                  cmd;
      logic signed [SUM_WIDTH-1:0] s_real;
      logic signed [SUM_WIDTH-1:0] s_imag;
      logic [DEN_WIDTH-1:0]        den;
   } entry_type;
endpackage
`default_nettype wire

FILE: hw/rtl/cau_front.sv
// Front end: accepts requests, forms products and sums.
`default_nettype none
module cau_front (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output logic                     req_ready,
   input  wire cau_pkg::req_type    req,
   output logic                     out_valid,
   input  wire logic                out_ready,
   output cau_pkg::entry_type       out_entry
);
   localparam int W  = cau_pkg::DATA_WIDTH;
   localparam int SW = cau_pkg::SUM_WIDTH;
   localparam int DW = cau_pkg::DEN_WIDTH;

   logic             a_valid_ff, b_valid_ff, a_adv, b_adv, a_mag;
   cau_pkg::req_type a_ff;
   logic [2:0]       b_cmd_ff;
   logic signed [W-1:0]   b_ar_ff, b_ai_ff, b_br_ff, b_bi_ff;
   logic signed [2*W-1:0] p0_ff, p1_ff, p2_ff, p3_ff, p4_ff, p5_ff;
   logic signed [2*W-1:0] p0_in, p1_in, p2_in, p3_in, p4_in, p5_in;

   assign b_adv     = !b_valid_ff || out_ready;
   assign a_adv     = !a_valid_ff || b_adv;
   assign req_ready = a_adv;
   assign a_mag     = (a_ff.cmd == cau_pkg::CMD_MAG);

   always_comb begin
      p0_in = a_ff.left_real * a_ff.right_real;
      p1_in = a_ff.left_imag * a_ff.right_imag;
      p2_in = a_ff.left_imag * a_ff.right_real;
      p3_in = a_ff.left_real * a_ff.right_imag;
      p4_in = a_mag ? a_ff.left_real * a_ff.left_real : a_ff.right_real * a_ff.right_real;
      p5_in = a_mag ? a_ff.left_imag * a_ff.left_imag : a_ff.right_imag * a_ff.right_imag;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
      end else begin
         if (a_adv) a_valid_ff <= req_valid;
         if (b_adv) b_valid_ff <= a_valid_ff;
      end
      if (a_adv) a_ff <= req;
      if (b_adv) begin
         b_cmd_ff <= a_ff.cmd;
         b_ar_ff  <= a_ff.left_real;
         b_ai_ff  <= a_ff.left_imag;
         b_br_ff  <= a_ff.right_real;
         b_bi_ff  <= a_ff.right_imag;
         p0_ff    <= p0_in;
         p1_ff    <= p1_in;
         p2_ff    <= p2_in;
         p3_ff    <= p3_in;
         p4_ff    <= p4_in;
         p5_ff    <= p5_in;
      end
   end

   always_comb begin
      out_entry.cmd    = b_cmd_ff;
      out_entry.s_real = '0;
      out_entry.s_imag = '0;
      out_entry.den    = DW'($unsigned(p4_ff)) + DW'($unsigned(p5_ff));
      case (b_cmd_ff)
         cau_pkg::CMD_ADD: begin
            out_entry.s_real = SW'(b_ar_ff) + SW'(b_br_ff);
            out_entry.s_imag = SW'(b_ai_ff) + SW'(b_bi_ff);
         end
         cau_pkg::CMD_SUB: begin
            out_entry.s_real = SW'(b_ar_ff) - SW'(b_br_ff);
            out_entry.s_imag = SW'(b_ai_ff) - SW'(b_bi_ff);
         end
         cau_pkg::CMD_NEG: begin
            out_entry.s_real = -SW'(b_ar_ff);
            out_entry.s_imag = -SW'(b_ai_ff);
         end
         cau_pkg::CMD_MUL: begin
            out_entry.s_real = SW'(p0_ff) - SW'(p1_ff);
            out_entry.s_imag = SW'(p2_ff) + SW'(p3_ff);
         end
         cau_pkg::CMD_DIV: begin
            out_entry.s_real = SW'(p0_ff) + SW'(p1_ff);
            out_entry.s_imag = SW'(p2_ff) - SW'(p3_ff);
         end
         default: ;
      endcase
   end

   assign out_valid = b_valid_ff;
endmodule
`default_nettype wire

FILE: hw/rtl/cau_queue.sv
// Four-entry queue between front and back.
`default_nettype none
module cau_queue (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               push,
   input  wire cau_pkg::entry_type din,
   input  wire logic               pop,
   output cau_pkg::entry_type      dout,
   output logic                    full,
   output logic                    empty
);
   localparam int DEPTH = 4;
   localparam int AW    = $clog2(DEPTH);

   cau_pkg::entry_type mem_ff [DEPTH];
   logic [AW-1:0] wr_ff, rd_ff;
   logic [AW:0]   cnt_ff;

   assign full  = (cnt_ff == (AW+1)'(DEPTH));
   assign empty = (cnt_ff == '0);
   assign dout  = mem_ff[rd_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         if (push) wr_ff <= wr_ff + 1'b1;
         if (pop) rd_ff <= rd_ff + 1'b1;
         if (push && !pop) cnt_ff <= cnt_ff + 1'b1;
         else if (pop && !push) cnt_ff <= cnt_ff - 1'b1;
      end
      if (push) mem_ff[wr_ff] <= din;
   end
endmodule
`default_nettype wire

FILE: hw/rtl/cau_back.sv
// Back end: saturation, shared divide and square-root iteration, result register.
`default_nettype none
module cau_back #(
   parameter int FRAC_BITS = 8
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               in_valid,
   input  wire cau_pkg::entry_type in_entry,
   output logic                    in_pop,
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output cau_pkg::rsp_type        rsp
);
   localparam int W  = cau_pkg::DATA_WIDTH;
   localparam int SW = cau_pkg::SUM_WIDTH;
   localparam int DW = cau_pkg::DEN_WIDTH;
   localparam int NW = 2 * W + FRAC_BITS;
   localparam int CW = $clog2(NW + 1);
   localparam logic signed [SW-1:0] POS_S = SW'((64'sd1 <<< (W - 1)) - 64'sd1);
   localparam logic signed [SW-1:0] NEG_S = -POS_S - SW'(1);
   localparam logic [W:0] POS_M = (W+1)'((64'd1 << (W - 1)) - 64'd1);
   localparam logic [W:0] NEG_M = (W+1)'(64'd1 << (W - 1));

   function automatic logic [W:0] sat_s(input logic signed [SW-1:0] v);
      logic [W:0] r;
      if (v > POS_S) r = {1'b1, POS_S[W-1:0]};
      else if (v < NEG_S) r = {1'b1, NEG_S[W-1:0]};
      else r = {1'b0, v[W-1:0]};
      return r;
   endfunction

   function automatic logic [W:0] sat_m(input logic neg, input logic [W:0] q, input logic big);
      logic [W:0] r;
      logic [W:0] nq;
      nq = ~q + 1'b1;
      if (!neg) r = (big || q > POS_M) ? {1'b1, POS_M[W-1:0]} : {1'b0, q[W-1:0]};
      else r = (big || q > NEG_M) ? {1'b1, NEG_M[W-1:0]} : {1'b0, nq[W-1:0]};
      return r;
   endfunction

   logic              busy_ff, busy_in, div_ff, div_in, nr_ff, nr_in, ni_ff, ni_in;
   logic              bigr_ff, bigr_in, bigi_ff, bigi_in;
   logic [CW-1:0]     cnt_ff, cnt_in;
   logic [DW-1:0]     den_ff, den_in;
   logic [NW-1:0]     nmr_ff, nmr_in, nmi_ff, nmi_in;
   logic [DW:0]       rr_ff, rr_in, ri_ff, ri_in, tr, ti, trial;
   logic [W:0]        qr_ff, qr_in, qi_ff, qi_in;
   logic              rsp_valid_ff, rsp_valid_in;
   cau_pkg::rsp_type  rsp_ff, rsp_in;
   logic              out_free, fin, head_iter;
   logic [W:0]        sr, si;
   logic [SW-1:0]     mag_r, mag_i;
   logic signed [SW-1:0] shr, shi;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign fin       = busy_ff && (cnt_ff == '0);
   assign head_iter = (in_entry.cmd == cau_pkg::CMD_MAG) ||
                      ((in_entry.cmd == cau_pkg::CMD_DIV) && (in_entry.den != '0));
   assign mag_r = in_entry.s_real[SW-1] ? -in_entry.s_real : in_entry.s_real;
   assign mag_i = in_entry.s_imag[SW-1] ? -in_entry.s_imag : in_entry.s_imag;
   assign shr   = in_entry.s_real >>> FRAC_BITS;
   assign shi   = in_entry.s_imag >>> FRAC_BITS;

   always_comb begin
      busy_in = busy_ff; div_in = div_ff; nr_in = nr_ff; ni_in = ni_ff;
      bigr_in = bigr_ff; bigi_in = bigi_ff; cnt_in = cnt_ff; den_in = den_ff;
      nmr_in = nmr_ff; nmi_in = nmi_ff; rr_in = rr_ff; ri_in = ri_ff;
      qr_in = qr_ff; qi_in = qi_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_in = rsp_ff;
      in_pop = 1'b0;
      sr = '0; si = '0;
      tr = '0; ti = '0; trial = '0;

      if (busy_ff && cnt_ff != '0) begin
         cnt_in = cnt_ff - 1'b1;
         if (div_ff) begin
            tr = {rr_ff[DW-1:0], nmr_ff[NW-1]};
            ti = {ri_ff[DW-1:0], nmi_ff[NW-1]};
            nmr_in = nmr_ff << 1;
            nmi_in = nmi_ff << 1;
            bigr_in = bigr_ff | qr_ff[W];
            bigi_in = bigi_ff | qi_ff[W];
            if (tr >= {1'b0, den_ff}) begin
               rr_in = tr - {1'b0, den_ff};
               qr_in = {qr_ff[W-1:0], 1'b1};
            end else begin
               rr_in = tr;
               qr_in = {qr_ff[W-1:0], 1'b0};
            end
            if (ti >= {1'b0, den_ff}) begin
               ri_in = ti - {1'b0, den_ff};
               qi_in = {qi_ff[W-1:0], 1'b1};
            end else begin
               ri_in = ti;
               qi_in = {qi_ff[W-1:0], 1'b0};
            end
         end else begin
            tr    = {rr_ff[DW-2:0], nmr_ff[NW-1:NW-2]};
            trial = (DW+1)'({qr_ff, 2'b01});
            nmr_in = nmr_ff << 2;
            if (tr >= trial) begin
               rr_in = tr - trial;
               qr_in = {qr_ff[W-1:0], 1'b1};
            end else begin
               rr_in = tr;
               qr_in = {qr_ff[W-1:0], 1'b0};
            end
         end
      end

      if (fin) begin
         if (out_free) begin
            if (div_ff) begin
               sr = sat_m(nr_ff, qr_ff, bigr_ff);
               si = sat_m(ni_ff, qi_ff, bigi_ff);
            end else begin
               sr = sat_m(1'b0, qr_ff, 1'b0);
            end
            rsp_in.res_real = sr[W-1:0];
            rsp_in.res_imag = si[W-1:0];
            rsp_in.status   = (sr[W] | si[W]) ? cau_pkg::ST_SAT : cau_pkg::ST_OK;
            rsp_valid_in    = 1'b1;
            busy_in         = 1'b0;
         end
      end else if (in_valid && !busy_ff && !head_iter) begin
         if (out_free) begin
            in_pop = 1'b1;
            rsp_in.status = cau_pkg::ST_OK;
            case (in_entry.cmd)
               cau_pkg::CMD_ADD, cau_pkg::CMD_SUB, cau_pkg::CMD_NEG: begin
                  sr = sat_s(in_entry.s_real);
                  si = sat_s(in_entry.s_imag);
               end
               cau_pkg::CMD_MUL: begin
                  sr = sat_s(shr);
                  si = sat_s(shi);
               end
               cau_pkg::CMD_DIV: rsp_in.status = cau_pkg::ST_DIV0;
               default: ;
            endcase
            rsp_in.res_real = sr[W-1:0];
            rsp_in.res_imag = si[W-1:0];
            if (sr[W] | si[W]) rsp_in.status = cau_pkg::ST_SAT;
            rsp_valid_in = 1'b1;
         end
      end else if (in_valid && !busy_ff) begin
         in_pop  = 1'b1;
         busy_in = 1'b1;
         div_in  = (in_entry.cmd == cau_pkg::CMD_DIV);
         den_in  = in_entry.den;
         nr_in   = in_entry.s_real[SW-1];
         ni_in   = in_entry.s_imag[SW-1];
         bigr_in = 1'b0;
         bigi_in = 1'b0;
         rr_in   = '0;
         ri_in   = '0;
         qr_in   = '0;
         qi_in   = '0;
         nmi_in  = NW'(mag_i[2*W-1:0]) << FRAC_BITS;
         if (in_entry.cmd == cau_pkg::CMD_DIV) begin
            nmr_in = NW'(mag_r[2*W-1:0]) << FRAC_BITS;
            cnt_in = CW'(NW);
         end else begin
            nmr_in = NW'(in_entry.den[2*W-1:0]) << FRAC_BITS;
            cnt_in = CW'(W);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      div_ff  <= div_in;
      nr_ff   <= nr_in;
      ni_ff   <= ni_in;
      bigr_ff <= bigr_in;
      bigi_ff <= bigi_in;
      den_ff  <= den_in;
      nmr_ff  <= nmr_in;
      nmi_ff  <= nmi_in;
      rr_ff   <= rr_in;
      ri_ff   <= ri_in;
      qr_ff   <= qr_in;
      qi_ff   <= qi_in;
      rsp_ff  <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;
endmodule
`default_nettype wire

FILE: hw/rtl/complex_arithmetic_unit.sv
// Complex arithmetic unit top level.
// Requests enter on req_valid/req_ready with a command and two complex
// operands in signed fixed point; each request gives one response on
// rsp_valid/rsp_ready with real and imaginary parts and a status.
// The front end registers the request, forms all products in one stage and
// the sums in the next, and writes a four-entry queue. The back end finishes
// add, subtract, multiply, negate, zero-divisor and unknown commands straight
// into the response register, so those run at one request per cycle while
// the response is not stalled and no divide or magnitude is iterating.
// Divide runs a bit-serial restoring divider and magnitude a digit-by-digit
// square root, both in one shared unit; while it iterates, later requests
// wait behind it, so these commands set the rate.
// Responses leave in request order. The front end keeps taking requests while
// the back end iterates until the queue fills.
// A stalled response holds in the response register; the queue and front
// stages fill behind it and req_ready drops only when they are full.
// Synchronous reset empties all stages and the queue; nothing else is cleared.
`default_nettype none
`include "complex_arithmetic_unit_macros.svh"
module complex_arithmetic_unit #(
   parameter int FRAC_BITS = 8
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_ready,
   input  wire cau_pkg::req_type req,
   output logic                  rsp_valid,
   input  wire logic             rsp_ready,
   output cau_pkg::rsp_type      rsp
);
   logic               f_valid;
   cau_pkg::entry_type f_entry, q_head;
   logic               q_push, q_pop, q_full, q_empty;

   assign q_push = f_valid && !q_full;

   cau_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req       (req),
      .out_valid (f_valid),
      .out_ready (!q_full),
      .out_entry (f_entry)
   );

   cau_queue u_queue (
      .clock (clock),
      .reset (reset),
      .push  (q_push),
      .din   (f_entry),
      .pop   (q_pop),
      .dout  (q_head),
      .full  (q_full),
      .empty (q_empty)
   );

   cau_back #(.FRAC_BITS(FRAC_BITS)) u_back (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (!q_empty),
      .in_entry  (q_head),
      .in_pop    (q_pop),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp       (rsp)
   );

   `CAU_ASSERT_IMPL(a_no_overflow, clock, reset, q_push, !q_full)
   `CAU_ASSERT_IMPL(a_no_underflow, clock, reset, q_pop, !q_empty)
   `CAU_ASSERT_IMPL(a_div0_zero, clock, reset, rsp_valid && rsp.status == cau_pkg::ST_DIV0, rsp.res_real == '0 && rsp.res_imag == '0)
   `CAU_ASSERT_NEXT(a_empty_push, clock, reset, q_empty && !q_push, q_empty)
endmodule
`default_nettype wire
